// ===== src/wsfu_pkg.sv =====
// websocket frame unmasker package: parse phase codes and header constants
// no dependencies; imported by websocket_frame_unmasker
package wsfu_pkg;

  localparam logic [2:0] PH_HDR = 3'd0;
  localparam logic [2:0] PH_LEN = 3'd1;
  localparam logic [2:0] PH_EXT = 3'd2;
  localparam logic [2:0] PH_KEY = 3'd3;
  localparam logic [2:0] PH_PAY = 3'd4;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// ===== src/websocket_frame_unmasker.sv =====
// Takes one byte of a back-to-back masked client frame stream per cycle. Header, length,
// extended length and key bytes give no result; each payload byte comes out unmasked in the
// cycle after it is taken, with is_last on the final byte of its frame. One byte per cycle
// sustained; the only thing that holds the input is a result in the output register that
// the downstream side is stalling.
// depends on wsfu_pkg
module websocket_frame_unmasker
  import wsfu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       is_last
);

  logic [2:0]  phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [63:0] payload_remaining, payload_remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_index, key_index_next;

  logic        accept;
  logic        emit;
  logic        last;
  logic [7:0]  key_byte;
  logic [3:0]  count_dec;
  logic [6:0]  len7;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign last     = (payload_remaining[63:1] == 63'd0);
  assign count_dec = header_count - 4'd1;
  assign len7     = data_byte[6:0];

  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    payload_remaining_next = payload_remaining;
    mask_key_next          = mask_key;
    key_index_next         = key_index;
    emit                   = 1'b0;
    case (phase)
      PH_LEN: begin
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          phase_next             = PH_EXT;
          header_count_next      = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          payload_remaining_next = 64'd0;
        end else begin
          payload_remaining_next = {57'd0, len7};
          phase_next             = PH_KEY;
          header_count_next      = KEY_BYTES;
          mask_key_next          = 32'd0;
          key_index_next         = 2'd0;
        end
      end
      PH_EXT: begin
        payload_remaining_next = {payload_remaining[55:0], data_byte};
        header_count_next      = count_dec;
        if (count_dec == 4'd0) begin
          phase_next        = PH_KEY;
          header_count_next = KEY_BYTES;
          mask_key_next     = 32'd0;
          key_index_next    = 2'd0;
        end
      end
      PH_KEY: begin
        mask_key_next     = {mask_key[23:0], data_byte};
        header_count_next = count_dec;
        if (count_dec == 4'd0) begin
          key_index_next = 2'd0;
          phase_next     = (payload_remaining == 64'd0) ? PH_HDR : PH_PAY;
        end
      end
      PH_PAY: begin
        emit           = 1'b1;
        key_index_next = key_index + 2'd1;
        if (last) begin
          payload_remaining_next = 64'd0;
          key_index_next         = 2'd0;
          header_count_next      = 4'd0;
          phase_next             = PH_HDR;
        end else begin
          payload_remaining_next = payload_remaining - 64'd1;
        end
      end
      default: begin
        phase_next        = PH_LEN;
        header_count_next = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR;
      header_count      <= 4'd0;
      payload_remaining <= 64'd0;
      mask_key          <= 32'd0;
      key_index         <= 2'd0;
    end else if (accept) begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      payload_remaining <= payload_remaining_next;
      mask_key          <= mask_key_next;
      key_index         <= key_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      payload_byte <= data_byte ^ key_byte;
      is_last      <= last;
    end
  end

  // payload phase always has bytes left
  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> payload_remaining != 64'd0)
    else $error("payload phase with zero remaining");

  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EXT || phase == PH_KEY) |-> header_count != 4'd0)
    else $error("header phase with zero count");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_PAY && last) |=> (phase == PH_HDR && out_valid && is_last))
    else $error("final payload beat did not end frame");

  a_no_result_header: assert property (@(posedge clk) disable iff (rst)
    (accept && phase != PH_PAY) |=> !out_valid)
    else $error("result from header beat");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

endmodule

// ===== verif/tb.sv =====
// testbench for websocket_frame_unmasker: frame streams go in byte by byte, and each
// unmasked payload beat is checked against a local frame parser and unmasker
// depends on wsfu_pkg and websocket_frame_unmasker
module tb
  import wsfu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_last;
  } beat_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] payload_byte;
  logic       is_last;

  logic [2:0]  ph;
  logic [3:0]  hdr_left;
  logic [63:0] bytes_left;
  logic [31:0] mask_key;
  logic [1:0]  key_idx;

  beat_t expected_beats[$];
  int    err_count;
  int    bytes_sent;
  bit    tx_idle;
  bit    rx_idle;
  int    rx_wait;
  int    hold_req;
  int    hold_left;

  websocket_frame_unmasker u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .payload_byte(payload_byte),
    .is_last     (is_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // frame parser and unmasker, one call per accepted byte
  function automatic void unmask_predict(input logic [7:0] b);
    beat_t r;
    case (ph)
      PH_LEN: begin
        if (b[6:0] == LEN_EXT16) begin
          ph = PH_EXT;
          hdr_left = EXT16_BYTES;
          bytes_left = '0;
        end else if (b[6:0] == LEN_EXT64) begin
          ph = PH_EXT;
          hdr_left = EXT64_BYTES;
          bytes_left = '0;
        end else begin
          bytes_left = {57'd0, b[6:0]};
          ph = PH_KEY;
          hdr_left = KEY_BYTES;
          mask_key = '0;
          key_idx = '0;
        end
      end
      PH_EXT: begin
        bytes_left = {bytes_left[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          ph = PH_KEY;
          hdr_left = KEY_BYTES;
          mask_key = '0;
          key_idx = '0;
        end
      end
      PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          key_idx = '0;
          ph = (bytes_left == 64'd0) ? PH_HDR : PH_PAY;
        end
      end
      PH_PAY: begin
        r.payload_byte = b ^ mask_key[8 * (3 - key_idx) +: 8];
        r.is_last = (bytes_left <= 64'd1);
        expected_beats.insert(expected_beats.size(), r);
        key_idx = key_idx + 2'd1;
        if (r.is_last) begin
          bytes_left = '0;
          key_idx = '0;
          hdr_left = '0;
          ph = PH_HDR;
        end else begin
          bytes_left = bytes_left - 64'd1;
        end
      end
      default: begin
        ph = PH_LEN;
        hdr_left = '0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    data_byte = b;
    do @(posedge clk); while (in_stall);
    unmask_predict(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic mask_bit, input int kind,
                            input logic [63:0] len, input logic [31:0] key,
                            input longint n_pay);
    send_byte(hdr);
    if (kind == 0) begin
      send_byte({mask_bit, len[6:0]});
    end else if (kind == 1) begin
      send_byte({mask_bit, LEN_EXT16});
      for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end else begin
      send_byte({mask_bit, LEN_EXT64});
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    repeat (n_pay) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    int sel;
    int len;
    int kind;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      kind = 0;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
    end else if (sel < 9) begin
      kind = 1;
      len = $urandom_range(0, 300);
    end else begin
      kind = 2;
      len = $urandom_range(0, 40);
    end
    send_frame(8'($urandom), 1'($urandom), kind, 64'(len), $urandom, len);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_frame(8'h81, 1'b1, 0, 64'd1, 32'h0000_0000, 1);
    send_frame(8'h00, 1'b0, 0, 64'd5, 32'hFFFF_FFFF, 5);
    send_frame(8'hFF, 1'b1, 0, 64'd0, 32'hA5A5_5A5A, 0);
    send_frame(8'h82, 1'b1, 1, 64'd0, 32'h1234_5678, 0);
    send_frame(8'h82, 1'b0, 2, 64'd0, 32'h8765_4321, 0);
    send_frame(8'h01, 1'b1, 0, 64'd125, 32'h0102_0304, 125);
    send_frame(8'h02, 1'b1, 1, 64'd126, 32'hDEAD_BEEF, 126);
    send_frame(8'h80, 1'b0, 1, 64'd3, 32'h8040_2010, 3);
    send_frame(8'h7F, 1'b1, 2, 64'd2, 32'hFEDC_BA98, 2);
  endtask

  task automatic test_random(input int n_bytes, input bit idle);
    int stop_at;
    tx_idle = idle;
    rx_idle = idle;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = 300;
    send_frame(8'h82, 1'b1, 0, 64'd80, $urandom, 80);
    send_random_frame();
  endtask

  task automatic test_drain_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (3) send_random_frame();
    drain();
    repeat (3) send_random_frame();
  endtask

  // raw bytes; extended lengths kept to the low byte so the stream stays short
  task automatic test_noise();
    int stop_at;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    stop_at = bytes_sent + 150;
    while (bytes_sent < stop_at || ph != PH_HDR) begin
      if (ph == PH_EXT && hdr_left > 4'd1) send_byte(8'h00);
      else send_byte(8'($urandom));
    end
  endtask

  // length with top bit set never ends, so this runs last
  task automatic test_huge_length();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_frame(8'h82, 1'b1, 2, 64'h8000_0000_0000_0007, $urandom, 20);
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (rx_wait > 0) begin
      out_stall = 1'b1;
      rx_wait--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    beat_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      rx_wait = rx_idle ? $urandom_range(0, 5) : 0;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat payload_byte %h is_last %b",
                 $time, payload_byte, is_last);
        err_count++;
      end else begin
        exp_beat = expected_beats.pop_front();
        if (payload_byte !== exp_beat.payload_byte) begin
          $display("%0t: payload_byte expected %h got %h",
                   $time, exp_beat.payload_byte, payload_byte);
          err_count++;
        end
        if (is_last !== exp_beat.is_last) begin
          $display("%0t: is_last expected %b got %b", $time, exp_beat.is_last, is_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    out_stall = 1'b0;
    ph = PH_HDR;
    hdr_left = '0;
    bytes_left = '0;
    mask_key = '0;
    key_idx = '0;
    err_count = 0;
    bytes_sent = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_wait = 0;
    hold_req = 0;
    hold_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(450, 1'b1);
    test_random(300, 1'b0);
    test_backpressure();
    test_drain_pause();
    test_random(150, 1'b1);
    test_noise();
    test_huge_length();

    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_beats.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
